@@ hdl/pese_pkg.sv @@
// Package for the prefix expression stack evaluator.
// Holds stack depth, action and status codes, and transaction payload structs.
// No dependencies.
package pese_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned CntW       = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIVZERO   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] operand;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [2:0]         status;
  } out_item_t;

  // stack shift command shared by all cells
  typedef struct packed {
    logic push;     // shift down, insert at top
    logic pop2;     // shift up by two
    logic replace;  // with pop2: top becomes new value
    logic clear;
  } stk_cmd_t;

endpackage

@@ hdl/pese_cell.sv @@
// One stack cell of the evaluator: holds one value, shifts with neighbors.
// Depends on pese_pkg.
module pese_cell (
  input  logic                  clk_i,
  input  pese_pkg::stk_cmd_t    cmd_i,
  input  logic signed [31:0]    above_i,   // toward top (or new value for top cell)
  input  logic signed [31:0]    below1_i,  // next deeper cell
  input  logic signed [31:0]    below2_i,  // two deeper
  input  logic                  is_top_i,
  output logic signed [31:0]    val_o
);
  import pese_pkg::*;

  logic signed [31:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (cmd_i.push) begin
      val_d = above_i;
    end else if (cmd_i.pop2) begin
      // replace: top gets new value, others pull up by one
      if (cmd_i.replace && is_top_i) val_d = above_i;
      else if (cmd_i.replace)        val_d = below1_i;
      else                           val_d = below2_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
endmodule

@@ hdl/pese_alu.sv @@
// Q16.16 arithmetic for the evaluator: add/sub, registered multiply, serial divide.
// Depends on pese_pkg.
module pese_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] res_o,
  output logic               sat_o,
  output logic               dz_o
);
  import pese_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} astate_e;

  astate_e            st_q;
  logic [5:0]         cnt_q;
  logic [47:0]        num_q;   // |a| << 16
  logic [31:0]        den_q;
  logic [48:0]        rem_q;
  logic [47:0]        quo_q;
  logic               neg_q;
  logic signed [63:0] prod_q;
  logic               done_q, sat_q, dz_q;
  logic signed [31:0] res_q;

  logic signed [32:0] sum;
  logic signed [63:0] pq;
  logic signed [64:0] sq;
  logic [48:0]        rsh;
  logic [48:0]        rsub;

  assign sum = (op_i == ACT_SUB) ? (33'(a_i) - 33'(b_i)) : (33'(a_i) + 33'(b_i));
  // truncate toward zero on /65536
  assign pq  = (prod_q < 0) ? -((-prod_q) >>> 16) : (prod_q >>> 16);
  assign rsh = {rem_q[47:0], num_q[47]};
  assign rsub = rsh - {17'd0, den_q};
  assign sq  = neg_q ? -$signed({17'd0, quo_q}) : $signed({17'd0, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        A_IDLE: begin
          if (start_i) begin
            dz_q <= 1'b0;
            sat_q <= 1'b0;
            if (op_i == ACT_MUL) begin
              prod_q <= 64'(a_i) * 64'(b_i);
              st_q   <= A_MUL;
            end else if (op_i == ACT_DIV) begin
              if (b_i == 32'sd0) begin
                res_q  <= '0;
                dz_q   <= 1'b1;
                done_q <= 1'b1;
              end else begin
                num_q <= {(a_i[31] ? 32'(-a_i) : 32'(a_i)), 16'd0};
                den_q <= b_i[31] ? 32'(-b_i) : 32'(b_i);
                neg_q <= a_i[31] ^ b_i[31];
                rem_q <= '0;
                quo_q <= '0;
                cnt_q <= 6'd47;
                st_q  <= A_DIV;
              end
            end else begin
              if (sum > 33'sh0_7FFF_FFFF) begin
                res_q <= 32'sh7FFF_FFFF; sat_q <= 1'b1;
              end else if (sum < -33'sh0_8000_0000) begin
                res_q <= 32'sh8000_0000; sat_q <= 1'b1;
              end else begin
                res_q <= sum[31:0];
              end
              done_q <= 1'b1;
            end
          end
        end
        A_MUL: begin
          if (pq > 64'sh7FFF_FFFF) begin
            res_q <= 32'sh7FFF_FFFF; sat_q <= 1'b1;
          end else if (pq < -64'sh8000_0000) begin
            res_q <= 32'sh8000_0000; sat_q <= 1'b1;
          end else begin
            res_q <= pq[31:0];
          end
          done_q <= 1'b1;
          st_q   <= A_IDLE;
        end
        A_DIV: begin
          // restoring divide, one quotient bit per cycle
          num_q <= {num_q[46:0], 1'b0};
          if (!rsub[48]) begin
            rem_q <= rsub;
            quo_q <= {quo_q[46:0], 1'b1};
          end else begin
            rem_q <= rsh;
            quo_q <= {quo_q[46:0], 1'b0};
          end
          if (cnt_q == 6'd0) st_q <= A_FIN;
          else cnt_q <= cnt_q - 6'd1;
        end
        A_FIN: begin
          if (sq > 65'sh7FFF_FFFF) begin
            res_q <= 32'sh7FFF_FFFF; sat_q <= 1'b1;
          end else if (sq < -65'sh8000_0000) begin
            res_q <= 32'sh8000_0000; sat_q <= 1'b1;
          end else begin
            res_q <= sq[31:0];
          end
          done_q <= 1'b1;
          st_q   <= A_IDLE;
        end
        default: st_q <= A_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;
  assign dz_o   = dz_q;
endmodule

@@ hdl/prefix_expression_stack_evaluator_unit.sv @@
// Top level of the prefix expression stack evaluator.
// Depends on pese_pkg, pese_cell, pese_alu.
//
// Usage: tokens of a prefix expression, already reversed, come in one per
// input transaction (in_valid_i / in_stall_o / in_data_i). An operand is
// pushed; an operator pops a (top) and b and pushes a op b in Q16.16 with
// saturation. The transaction with last set produces one output transaction
// (out_valid_o / out_stall_i / out_data_o) carrying top of stack and status,
// then the stack and error latch clear.
// Timing: one transaction at a time. Add/sub, multiply and divide run in the
// arithmetic unit (divide: 48-bit restoring divider, one quotient bit per
// cycle). The last token passes through S_END to load the output register.
// The stack is a row of StackDepth cells that shift as a whole on each
// push or pop; the top two cells feed the arithmetic unit directly.
// Reset clears stack count, error latch and handshake state; cell contents
// are left as they are. While the output register holds an untaken result
// (out_stall_i high), new input is still accepted unless it is another
// last token, which waits until the output register is free.
module prefix_expression_stack_evaluator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pese_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pese_pkg::out_item_t  out_data_o
);
  import pese_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ALU, S_END} state_e;

  state_e             state_q;
  logic [CntW-1:0]    cnt_q;
  logic [2:0]         err_q;
  logic               last_q;
  logic               out_valid_q;
  out_item_t          out_q;
  stk_cmd_t           cmd;
  logic signed [31:0] new_val;
  logic signed [31:0] vals [StackDepth+2];
  logic               acc;
  logic               alu_start;
  logic               alu_done, alu_sat, alu_dz;
  logic signed [31:0] alu_res;
  logic [2:0]         err_now;

  // pad two zero cells below the bottom
  assign vals[StackDepth]   = '0;
  assign vals[StackDepth+1] = '0;

  for (genvar g = 0; g < StackDepth; g++) begin : g_cell
    pese_cell u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .above_i  ((g == 0) ? new_val : vals[(g == 0) ? 0 : g-1]),
      .below1_i (vals[g+1]),
      .below2_i (vals[g+2]),
      .is_top_i (g == 0),
      .val_o    (vals[g])
    );
  end

  assign in_stall_o = (state_q != S_IDLE) || (in_data_i.last && out_valid_q);
  assign acc        = in_valid_i && !in_stall_o;
  assign alu_start  = acc && (in_data_i.action >= ACT_ADD) &&
                      (in_data_i.action <= ACT_DIV) && (cnt_q >= CntW'(2));

  pese_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .op_i    (in_data_i.action),
    .a_i     (vals[0]),
    .b_i     (vals[1]),
    .done_o  (alu_done),
    .res_o   (alu_res),
    .sat_o   (alu_sat),
    .dz_o    (alu_dz)
  );

  always_comb begin
    cmd     = '0;
    new_val = in_data_i.operand;
    if (acc && in_data_i.action == ACT_PUSH && cnt_q < CntW'(StackDepth)) begin
      cmd.push = 1'b1;
    end else if (state_q == S_ALU && alu_done) begin
      cmd.pop2    = 1'b1;
      cmd.replace = 1'b1;
      new_val     = alu_res;
    end
  end

  always_comb begin
    err_now = err_q;
    if (state_q == S_ALU && alu_done && err_q == ST_OK) begin
      if (alu_dz)       err_now = ST_DIVZERO;
      else if (alu_sat) err_now = ST_SATURATED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            last_q <= in_data_i.last;
            if (in_data_i.action == ACT_PUSH) begin
              if (cnt_q < CntW'(StackDepth)) cnt_q <= cnt_q + CntW'(1);
              else if (err_q == ST_OK)      err_q <= ST_OVERFLOW;
              state_q <= in_data_i.last ? S_END : S_IDLE;
            end else if (in_data_i.action <= ACT_DIV) begin
              if (cnt_q < CntW'(2)) begin
                if (err_q == ST_OK) err_q <= ST_UNDERFLOW;
                state_q <= in_data_i.last ? S_END : S_IDLE;
              end else begin
                state_q <= S_ALU;
              end
            end else begin
              state_q <= in_data_i.last ? S_END : S_IDLE;
            end
          end
        end
        S_ALU: begin
          if (alu_done) begin
            cnt_q   <= cnt_q - CntW'(1);
            err_q   <= err_now;
            state_q <= last_q ? S_END : S_IDLE;
          end
        end
        S_END: begin
          out_valid_q <= 1'b1;
          if (cnt_q == '0) begin
            out_q.result <= '0;
            out_q.status <= (err_q == ST_OK) ? ST_UNDERFLOW : err_q;
          end else begin
            out_q.result <= vals[0];
            out_q.status <= err_q;
          end
          cnt_q   <= '0;
          err_q   <= ST_OK;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

@@ tb/tb_top.sv @@
// Testbench for the prefix expression stack evaluator unit.
// Drives reversed prefix token streams, predicts top of stack and status.
// Depends on pese_pkg and prefix_expression_stack_evaluator_unit.
`timescale 1ns / 1ps

module tb_top;
  import pese_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int signed   QOne          = 32'sh0001_0000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  prefix_expression_stack_evaluator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic signed [31:0] eval_stack[StackDepth];
  int unsigned        eval_depth;
  status_e            eval_err;
  out_item_t          expected_q[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned tokens_sent;
  int unsigned idle_cycles;
  bit          idle_enable;
  bit          done_sending;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  function automatic void latch_status(input status_e code);
    if (eval_err == ST_OK) eval_err = code;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sh7FFF_FFFF) begin
      latch_status(ST_SATURATED);
      return 32'sh7FFF_FFFF;
    end
    if (v < -96'sh8000_0000) begin
      latch_status(ST_SATURATED);
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void evaluate_token(input in_item_t tok);
    logic signed [95:0] a;
    logic signed [95:0] b;
    logic signed [95:0] wide;
    logic signed [31:0] r;
    out_item_t exp_out;
    if (tok.action == ACT_PUSH) begin
      if (eval_depth >= StackDepth) latch_status(ST_OVERFLOW);
      else begin
        eval_stack[eval_depth] = tok.operand;
        eval_depth++;
      end
    end else if (tok.action <= ACT_DIV) begin
      if (eval_depth < 2) latch_status(ST_UNDERFLOW);
      else begin
        a = eval_stack[eval_depth-1];
        b = eval_stack[eval_depth-2];
        eval_depth -= 2;
        case (action_e'(tok.action))
          ACT_ADD: r = sat32(a + b);
          ACT_SUB: r = sat32(a - b);
          ACT_MUL: begin
            wide = a * b;
            r = sat32(wide / 65536);  // SV division truncates toward zero
          end
          default: begin
            if (b == 0) begin
              latch_status(ST_DIVZERO);
              r = '0;
            end else begin
              wide = a * 65536;
              r = sat32(wide / b);
            end
          end
        endcase
        eval_stack[eval_depth] = r;
        eval_depth++;
      end
    end
    if (tok.last) begin
      if (eval_depth == 0) begin
        exp_out.result = '0;
        latch_status(ST_UNDERFLOW);
      end else exp_out.result = eval_stack[eval_depth-1];
      exp_out.status = eval_err;
      expected_q.push_back(exp_out);
      eval_depth = 0;
      eval_err = ST_OK;
    end
  endfunction

  // one token transaction; valid held until accepted, dropped only for a gap
  task automatic send_token(input logic [2:0] act, input logic signed [31:0] val,
                            input bit fin);
    in_item_t tok;
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      repeat (gap) @(negedge clk_i);
    end
    tok.action = act;
    tok.operand = val;
    tok.last = fin;
    in_data_i <= tok;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    evaluate_token(tok);
    tokens_sent++;
    @(negedge clk_i);
  endtask

  // sink stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_cycles > 0) begin
        idle_cycles--;
        if (idle_cycles == 0) out_stall_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        idle_cycles = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.result, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data_o.result !== want.result)
            report_mismatch("result", out_data_o.result, want.result);
          if (out_data_o.status !== want.status)
            report_mismatch("status", {29'd0, out_data_o.status}, {29'd0, want.status});
        end
      end
    end
  end

  // watchdog on handshake activity
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else if (in_valid_i || expected_q.size() != 0) quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("watchdog expired, %0d results pending", expected_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3: return 0;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic test_directed();
    // operands at the extremes and each operator
    send_token(ACT_PUSH, 32'sh7FFF_FFFF, 1'b0);
    send_token(ACT_PUSH, 32'sh7FFF_FFFF, 1'b0);
    send_token(ACT_ADD, 0, 1'b1);                 // saturates high
    send_token(ACT_PUSH, 32'sh8000_0000, 1'b0);
    send_token(ACT_PUSH, 32'sh0000_0001, 1'b0);
    send_token(ACT_SUB, 0, 1'b1);                 // 1 - min saturates
    send_token(ACT_PUSH, 3 * QOne, 1'b0);
    send_token(ACT_PUSH, -2 * QOne, 1'b0);
    send_token(ACT_MUL, 0, 1'b1);
    send_token(ACT_PUSH, 0, 1'b0);
    send_token(ACT_PUSH, QOne, 1'b0);
    send_token(ACT_DIV, 0, 1'b1);                 // divide by zero
    send_token(ACT_PUSH, -7 * QOne, 1'b0);
    send_token(ACT_PUSH, 2 * QOne, 1'b0);
    send_token(ACT_DIV, 0, 1'b1);
    send_token(ACT_ADD, 0, 1'b1);                 // underflow on empty stack
    send_token(3'd5, 32'shFFFF_FFFF, 1'b1);       // unused code, empty at end
    send_token(ACT_PUSH, 32'sh0000_8000, 1'b0);
    send_token(3'd7, 0, 1'b0);
    send_token(ACT_PUSH, 32'sh8000_0000, 1'b1);   // leftover values
    send_token(ACT_PUSH, 32'sh0000_0001, 1'b0);
    send_token(ACT_PUSH, 32'sh8000_0000, 1'b0);
    send_token(ACT_DIV, 0, 1'b1);                 // min / tiny saturates
  endtask

  task automatic test_overflow();
    for (int i = 0; i <= StackDepth; i++)
      send_token(ACT_PUSH, $urandom(), i == StackDepth);
  endtask

  // well formed: operands then operators, sized to stay on the stack
  task automatic test_random_expressions(input int unsigned budget);
    int unsigned held;
    int unsigned n_ops;
    logic [2:0]  act;
    while (tokens_sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any code, any value, occasional end
        send_token(3'($urandom_range(0, 7)), rand_value(), $urandom_range(0, 3) == 0);
      end else begin
        n_ops = $urandom_range(0, 6);
        held = 0;
        for (int k = 0; k <= n_ops; k++) begin
          send_token(ACT_PUSH, rand_value(), 1'b0);
          held++;
        end
        while (held > 1) begin
          act = 3'($urandom_range(ACT_ADD, ACT_DIV));
          send_token(act, rand_value(), held == 2);
          held--;
        end
        if (n_ops == 0) send_token(3'd6, rand_value(), 1'b1);
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    mismatches = 0;
    results_seen = 0;
    tokens_sent = 0;
    idle_cycles = 0;
    idle_enable = 1'b0;
    eval_depth = 0;
    eval_err = ST_OK;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    idle_enable = 1'b1;
    test_overflow();
    test_random_expressions(650);
    idle_enable = 1'b0;
    test_random_expressions(850);
    drain_results();

    $display("covered %0d tokens and %0d expression results, including", tokens_sent,
             results_seen);
    $display("saturation, divide by zero, underflow, overflow and unused codes");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/pese_pkg.sv
hdl/pese_cell.sv
hdl/pese_alu.sv
hdl/prefix_expression_stack_evaluator_unit.sv
tb/tb_top.sv
